### src/cbqs_pkg.sv
package cbqs_pkg;

	localparam int CODE_W    = 8;
	localparam int INDEX_W   = 8;
	localparam int RND_W     = 16;
	localparam int FRAC_BITS = 16;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUANT = 1'b1;

	typedef struct packed {
		logic               valid;
		logic               cmd;
		logic [INDEX_W-1:0] entry_index;
		logic [RND_W-1:0]   rnd;
	} ctl_t;

endpackage

### src/cbqs_level.sv
module cbqs_level #(
	parameter int N   = 256,
	parameter int V   = 18,
	parameter int LVL = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  cbqs_pkg::ctl_t          ctl_i,
	input  logic [V-1:0]            value_i,
	input  logic [V-1:0]            x_i,
	input  logic [$clog2(N)-1:0]    pivot_i,
	input  logic [$clog2(N)-1:0]    lo_idx_i,
	input  logic [$clog2(N)-1:0]    hi_idx_i,
	input  logic [V-1:0]            lo_i,
	input  logic [V-1:0]            hi_i,
	input  logic [V-1:0]            val_i,
	output cbqs_pkg::ctl_t          ctl_o,
	output logic [V-1:0]            value_o,
	output logic [V-1:0]            x_o,
	output logic [$clog2(N)-1:0]    pivot_o,
	output logic [$clog2(N)-1:0]    lo_idx_o,
	output logic [$clog2(N)-1:0]    hi_idx_o,
	output logic [V-1:0]            lo_o,
	output logic [V-1:0]            hi_o,
	output logic [V-1:0]            val_o
);
	import cbqs_pkg::*;

	localparam int IW    = $clog2(N);
	localparam int START = N / 2 - 1;
	localparam int STEP  = (LVL == 0) ? 0 : ((N / 4) >> (LVL - 1));

	logic [V-1:0]  mem [N];
	logic [IW-1:0] pivot_n;
	logic [IW-1:0] lo_idx_n;
	logic [IW-1:0] hi_idx_n;
	logic [V-1:0]  lo_n;
	logic [V-1:0]  hi_n;
	logic          wr;

	always_comb begin
		pivot_n  = pivot_i;
		lo_idx_n = lo_idx_i;
		hi_idx_n = hi_idx_i;
		lo_n     = lo_i;
		hi_n     = hi_i;
		if (LVL == 0) begin
			pivot_n = IW'(START);
		end else if ($signed(x_i) > $signed(val_i)) begin
			lo_idx_n = pivot_i;
			lo_n     = val_i;
			pivot_n  = pivot_i + IW'(STEP);
		end else begin
			hi_idx_n = pivot_i;
			hi_n     = val_i;
			pivot_n  = pivot_i - IW'(STEP);
		end
	end

	assign wr = ctl_i.valid && (ctl_i.cmd == CMD_LOAD) && (32'(ctl_i.entry_index) < N);

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr) begin
				mem[IW'(ctl_i.entry_index)] <= value_i;
			end
			val_o <= mem[pivot_n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_o           <= value_i;
			x_o               <= x_i;
			pivot_o           <= pivot_n;
			lo_idx_o          <= lo_idx_n;
			hi_idx_o          <= hi_idx_n;
			lo_o              <= lo_n;
			hi_o              <= hi_n;
		end
	end

endmodule

### src/cbqs_decide.sv
module cbqs_decide #(
	parameter int N = 256,
	parameter int V = 18
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       mode,
	input  cbqs_pkg::ctl_t             ctl_i,
	input  logic [V-1:0]               value_i,
	input  logic [V-1:0]               x_i,
	input  logic [$clog2(N)-1:0]       pivot_i,
	input  logic [$clog2(N)-1:0]       lo_idx_i,
	input  logic [$clog2(N)-1:0]       hi_idx_i,
	input  logic [V-1:0]               lo_i,
	input  logic [V-1:0]               hi_i,
	input  logic [V-1:0]               val_i,
	output logic                       out_valid,
	output logic [cbqs_pkg::CODE_W-1:0] code
);
	import cbqs_pkg::*;

	localparam int IW  = $clog2(N);
	localparam int TOP = N - 1;

	logic [V-1:0]  e0_q;
	logic [V-1:0]  etop_q;
	logic          wr;

	logic [V-1:0]  lo_e;
	logic [V-1:0]  hi_e;
	logic          gt;
	logic [V:0]    x2;
	logic [V:0]    sum_hi;
	logic [V:0]    sum_lo;
	logic [IW-1:0] near;
	logic [V:0]    d;
	logic [V:0]    full;

	logic          v_s1;
	logic          q_s1;
	logic [RND_W-1:0] rnd_s1;
	logic [IW-1:0] near_s1;
	logic [IW-1:0] pivot_s1;
	logic [IW-1:0] outer_s1;
	logic [V:0]    dist_s1;
	logic [V:0]    full_s1;

	logic [V+RND_W-1:0]   prod;
	logic [IW-1:0]        pick;
	logic                 v_q;
	logic [CODE_W-1:0]    code_q;

	assign wr = ctl_i.valid && (ctl_i.cmd == CMD_LOAD);

	always_ff @(posedge clk) begin
		if (en && wr) begin
			if (32'(ctl_i.entry_index) == 0) begin
				e0_q <= value_i;
			end
			if (32'(ctl_i.entry_index) == TOP) begin
				etop_q <= value_i;
			end
		end
	end

	always_comb begin
		hi_e   = (hi_idx_i == IW'(TOP)) ? etop_q : hi_i;
		lo_e   = (lo_idx_i == '0) ? e0_q : lo_i;
		gt     = $signed(x_i) > $signed(val_i);
		x2     = {x_i, 1'b0};
		sum_hi = {hi_e[V-1], hi_e} + {val_i[V-1], val_i};
		sum_lo = {lo_e[V-1], lo_e} + {val_i[V-1], val_i};
		if (gt) begin
			near = ($signed(x2) > $signed(sum_hi)) ? hi_idx_i : pivot_i;
			d    = {hi_e[V-1], hi_e} - {x_i[V-1], x_i};
			full = {hi_e[V-1], hi_e} - {val_i[V-1], val_i};
		end else begin
			near = ($signed(x2) < $signed(sum_lo)) ? lo_idx_i : pivot_i;
			d    = {lo_e[V-1], lo_e} - {x_i[V-1], x_i};
			full = {val_i[V-1], val_i} - {lo_e[V-1], lo_e};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= ctl_i.valid && (ctl_i.cmd == CMD_QUANT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1     <= mode;
			rnd_s1   <= ctl_i.rnd;
			near_s1  <= near;
			pivot_s1 <= pivot_i;
			outer_s1 <= gt ? hi_idx_i : lo_idx_i;
			dist_s1  <= d[V] ? (~d + 1'b1) : d;
			full_s1  <= full;
		end
	end

	always_comb begin
		prod = (V + RND_W)'(rnd_s1) * (V + RND_W)'(full_s1[V-1:0]);
		if (!q_s1) begin
			pick = near_s1;
		end else if (full_s1 == '0) begin
			pick = pivot_s1;
		end else if (full_s1[V]) begin
			pick = outer_s1;
		end else begin
			pick = ({1'b0, prod} >= {dist_s1, {FRAC_BITS{1'b0}}}) ? outer_s1 : pivot_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_q <= CODE_W'(pick);
		end
	end

	assign out_valid = v_q;
	assign code      = code_q;

endmodule

### src/codebook_quantizer_binary_search.sv
// Channel  Dir  Beat fields (lowest bit up)
// s_axis   in   cmd, entry_index, entry_value, sample, random_fraction
// m_axis   out  code_index (quantize beats only)
// cfg      in   stochastic_mode, one write per cycle with cfg_wen
// One beat enters per cycle while s_tready is high; the path holds log2(CODEBOOK_ENTRIES) search
// levels plus two decision/output stages, with one codebook copy read per level.
// A load beat gives no output beat. All stages stall together while m_tready is
// low and m_tvalid is high. Reset clears valid bits and the mode; codebook
// contents are undefined until loaded.
module codebook_quantizer_binary_search #(
	parameter int CODEBOOK_ENTRIES = 256,
	parameter int VALUE_BITS       = 18
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// cmd, entry_index, entry_value, sample, random_fraction, zero pad
	input  logic [((2*VALUE_BITS+25+7)/8)*8-1:0]      s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// code_index
	output logic [cbqs_pkg::CODE_W-1:0]               m_tdata,
	input  logic                                      cfg_wen,
	input  logic                                      cfg_wdata
);
	import cbqs_pkg::*;

	localparam int N   = CODEBOOK_ENTRIES;
	localparam int V   = VALUE_BITS;
	localparam int IW  = $clog2(N);
	localparam int L   = IW;
	localparam int TOP = N - 1;

	localparam int OFS_IDX = 1;
	localparam int OFS_EV  = OFS_IDX + INDEX_W;
	localparam int OFS_X   = OFS_EV + V;
	localparam int OFS_RND = OFS_X + V;

	logic mode_q;
	logic en;

	ctl_t          ctl_w    [L+1];
	logic [V-1:0]  value_w  [L+1];
	logic [V-1:0]  x_w      [L+1];
	logic [IW-1:0] pivot_w  [L+1];
	logic [IW-1:0] lo_idx_w [L+1];
	logic [IW-1:0] hi_idx_w [L+1];
	logic [V-1:0]  lo_w     [L+1];
	logic [V-1:0]  hi_w     [L+1];
	logic [V-1:0]  val_w    [L+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wen) begin
			mode_q <= cfg_wdata;
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	assign ctl_w[0].valid       = s_tvalid;
	assign ctl_w[0].cmd         = s_tdata[0];
	assign ctl_w[0].entry_index = s_tdata[OFS_IDX +: INDEX_W];
	assign ctl_w[0].rnd         = s_tdata[OFS_RND +: RND_W];
	assign value_w[0]           = s_tdata[OFS_EV +: V];
	assign x_w[0]               = s_tdata[OFS_X +: V];
	assign pivot_w[0]           = '0;
	assign lo_idx_w[0]          = '0;
	assign hi_idx_w[0]          = IW'(TOP);
	assign lo_w[0]              = '0;
	assign hi_w[0]              = '0;
	assign val_w[0]             = '0;

	for (genvar j = 0; j < L; j++) begin : g_lvl
		cbqs_level #(.N(N), .V(V), .LVL(j)) u_lvl (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_i    (ctl_w[j]),
			.value_i  (value_w[j]),
			.x_i      (x_w[j]),
			.pivot_i  (pivot_w[j]),
			.lo_idx_i (lo_idx_w[j]),
			.hi_idx_i (hi_idx_w[j]),
			.lo_i     (lo_w[j]),
			.hi_i     (hi_w[j]),
			.val_i    (val_w[j]),
			.ctl_o    (ctl_w[j+1]),
			.value_o  (value_w[j+1]),
			.x_o      (x_w[j+1]),
			.pivot_o  (pivot_w[j+1]),
			.lo_idx_o (lo_idx_w[j+1]),
			.hi_idx_o (hi_idx_w[j+1]),
			.lo_o     (lo_w[j+1]),
			.hi_o     (hi_w[j+1]),
			.val_o    (val_w[j+1])
		);
	end

	cbqs_decide #(.N(N), .V(V)) u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.mode      (mode_q),
		.ctl_i     (ctl_w[L]),
		.value_i   (value_w[L]),
		.x_i       (x_w[L]),
		.pivot_i   (pivot_w[L]),
		.lo_idx_i  (lo_idx_w[L]),
		.hi_idx_i  (hi_idx_w[L]),
		.lo_i      (lo_w[L]),
		.hi_i      (hi_w[L]),
		.val_i     (val_w[L]),
		.out_valid (m_tvalid),
		.code      (m_tdata)
	);

endmodule
